// ===== hw/rtl/mrqs_pkg.sv =====
// ============================================================================
// mrqs_pkg
// Shared types, operation codes and defaults of the ready-queue scheduler.
// ============================================================================
package mrqs_pkg;

    localparam int NUM_PROCESSES_DEF     = 16;
    localparam int NUM_LEVELS_DEF        = 6;
    localparam int USER_SETTABLE_MAX_DEF = 6;

    localparam int PID_FW  = 4;
    localparam int PRIO_FW = 3;
    localparam int OP_W    = 3;

    localparam logic [PID_FW-1:0] PTP_RESET = 4'd15;

    localparam logic [OP_W-1:0] OP_ADMIT   = 3'd0;
    localparam logic [OP_W-1:0] OP_RELEASE = 3'd1;
    localparam logic [OP_W-1:0] OP_SETPRIO = 3'd2;
    localparam logic [OP_W-1:0] OP_BLOCK   = 3'd3;
    localparam logic [OP_W-1:0] OP_RDYBLK  = 3'd4;
    localparam logic [OP_W-1:0] OP_RDYPID  = 3'd5;
    localparam logic [OP_W-1:0] OP_GETPRIO = 3'd6;

    localparam logic [1:0] ST_NEW     = 2'd0;
    localparam logic [1:0] ST_READY   = 2'd1;
    localparam logic [1:0] ST_RUN     = 2'd2;
    localparam logic [1:0] ST_BLOCKED = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]    operation;
        logic [PID_FW-1:0]  target_pid;
        logic [PRIO_FW-1:0] new_priority;
        logic               preempt;
    } req_beat_t;

    typedef struct packed {
        logic               status;
        logic [PID_FW-1:0]  running_pid_out;
        logic               running_valid_out;
        logic [PRIO_FW-1:0] priority_out;
    } rsp_beat_t;

endpackage

// ===== hw/rtl/mrqs_entry_ram.sv =====
// ============================================================================
// mrqs_entry_ram
// Per-process table: synchronous RAM with registered read and one valid bit
// per entry; an entry never written reads as all zeros.
// ============================================================================
module mrqs_entry_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 10
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [DEPTH-1:0] vld_reg;
    logic [WIDTH-1:0] rdata_reg;
    logic             rvld_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            rvld_reg <= 1'b0;
        end
        else
        begin
            if (we)
            begin
                vld_reg[waddr] <= 1'b1;
            end
            if (re)
            begin
                rvld_reg <= vld_reg[raddr];
            end
        end
    end

    assign rdata = rvld_reg ? rdata_reg : '0;

endmodule

// ===== hw/rtl/mrqs_seq.sv =====
// ============================================================================
// mrqs_seq
// Operation sequencer: keeps the queue head/tail registers and the running
// process, and walks the per-process table through read-modify-write steps.
// ============================================================================
module mrqs_seq #(
    parameter int NUM_PROCESSES     = 16,
    parameter int NUM_LEVELS        = 6,
    parameter int USER_SETTABLE_MAX = 6,
    localparam int PW = $clog2(NUM_PROCESSES),
    localparam int LW = $clog2(NUM_LEVELS),
    localparam int EW = LW + 2 + PW + 1
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  mrqs_pkg::req_beat_t         cmd,
    input  logic [mrqs_pkg::PID_FW-1:0] ptp,
    input  logic                        ack,
    output logic                        idle,
    output logic                        done,
    output mrqs_pkg::rsp_beat_t         result,
    output logic                        mem_re,
    output logic [PW-1:0]               mem_raddr,
    output logic                        mem_we,
    output logic [PW-1:0]               mem_waddr,
    output logic [EW-1:0]               mem_wdata,
    input  logic [EW-1:0]               mem_rdata
);
    import mrqs_pkg::*;

    localparam logic [4:0] S_IDLE     = 5'd0;
    localparam logic [4:0] S_DECODE   = 5'd1;
    localparam logic [4:0] S_PUSH     = 5'd2;
    localparam logic [4:0] S_PUSH_RD  = 5'd3;
    localparam logic [4:0] S_REL      = 5'd4;
    localparam logic [4:0] S_REL_A    = 5'd5;
    localparam logic [4:0] S_REL_PICK = 5'd6;
    localparam logic [4:0] S_REL_POP  = 5'd7;
    localparam logic [4:0] S_REL_CHK  = 5'd8;
    localparam logic [4:0] S_REL_FIX  = 5'd9;
    localparam logic [4:0] S_REL_FIX2 = 5'd10;
    localparam logic [4:0] S_SP_RD    = 5'd11;
    localparam logic [4:0] S_SP_W1    = 5'd12;
    localparam logic [4:0] S_SP_W2    = 5'd13;
    localparam logic [4:0] S_SP_SET   = 5'd14;
    localparam logic [4:0] S_BLK_RD   = 5'd15;
    localparam logic [4:0] S_B4_RD    = 5'd16;
    localparam logic [4:0] S_R5_RD    = 5'd17;
    localparam logic [4:0] S_G6_RD    = 5'd18;
    localparam logic [4:0] S_FIN      = 5'd19;

    localparam logic KIND_R = 1'b0;
    localparam logic KIND_B = 1'b1;

    localparam logic [PW-1:0] CNT_LAST = PW'(NUM_PROCESSES - 1);

    function automatic logic [EW-1:0] ent(input logic [LW-1:0] l, input logic [1:0] s,
                                          input logic [PW-1:0] n, input logic v);
        return {l, s, n, v};
    endfunction

    // System level wins, then the lowest non-empty level.
    function automatic logic [LW:0] pick_level(input logic [NUM_LEVELS-1:0] v);
        logic [LW:0] r;
        r = '0;
        for (int i = NUM_LEVELS - 2; i >= 0; i--)
        begin
            if (v[i])
            begin
                r = {1'b1, LW'(i)};
            end
        end
        if (v[NUM_LEVELS-1])
        begin
            r = {1'b1, LW'(NUM_LEVELS - 1)};
        end
        return r;
    endfunction

    logic [4:0]            state_reg, state_next;
    logic [4:0]            ret_reg, ret_next;
    req_beat_t             cmd_reg, cmd_next;
    logic [PW-1:0]         run_pid_reg, run_pid_next;
    logic                  run_vld_reg, run_vld_next;
    logic                  err_reg, err_next;
    logic [LW-1:0]         prio_out_reg, prio_out_next;
    logic [PW-1:0]         qhead_reg [2][NUM_LEVELS];
    logic [PW-1:0]         qhead_next [2][NUM_LEVELS];
    logic [PW-1:0]         qtail_reg [2][NUM_LEVELS];
    logic [PW-1:0]         qtail_next [2][NUM_LEVELS];
    logic [NUM_LEVELS-1:0] qhv_reg [2];
    logic [NUM_LEVELS-1:0] qhv_next [2];
    logic                  qk_reg, qk_next;
    logic [LW-1:0]         ql_reg, ql_next;
    logic [PW-1:0]         qn_reg, qn_next;
    logic [PW-1:0]         t_reg, t_next;
    logic [PW-1:0]         old_reg, old_next;
    logic                  had_reg, had_next;
    logic [PW-1:0]         p_reg, p_next;
    logic [PW-1:0]         prev_reg, prev_next;
    logic [PW-1:0]         cnt_reg, cnt_next;
    logic [EW-1:0]         snap_reg, snap_next;
    logic [EW-1:0]         prevsnap_reg, prevsnap_next;

    logic [LW-1:0] rd_lvl;
    logic [1:0]    rd_st;
    logic [PW-1:0] rd_nxt;
    logic          rd_lnk;
    logic [PW-1:0] pid_c;
    logic [LW-1:0] prio_c;
    logic          pid_ok, lvl_ok, sp_ok, is_rel, rel_pre, rel_ok, sp_move;
    logic [LW:0]   rscan, bscan;

    assign rd_lvl = mem_rdata[EW-1:EW-LW];
    assign rd_st  = mem_rdata[PW+2:PW+1];
    assign rd_nxt = mem_rdata[PW:1];
    assign rd_lnk = mem_rdata[0];

    assign pid_c   = PW'(cmd_reg.target_pid);
    assign prio_c  = LW'(cmd_reg.new_priority);
    assign pid_ok  = int'(cmd_reg.target_pid) < NUM_PROCESSES;
    assign lvl_ok  = int'(cmd_reg.new_priority) < NUM_LEVELS;
    assign sp_ok   = int'(cmd_reg.target_pid) >= 1 && pid_ok
                     && int'(cmd_reg.target_pid) <= USER_SETTABLE_MAX
                     && int'(cmd_reg.new_priority) <= NUM_LEVELS - 3;
    assign is_rel  = cmd_reg.operation == OP_RELEASE;
    assign rel_pre = is_rel && cmd_reg.preempt;
    assign rel_ok  = !had_reg || p_reg == old_reg || rd_st == ST_NEW || rd_st == ST_READY;
    assign sp_move = rd_st != ST_BLOCKED && !(run_vld_reg && run_pid_reg == pid_c);
    assign rscan   = pick_level(qhv_reg[KIND_R]);
    assign bscan   = pick_level(qhv_reg[KIND_B]);

    always_comb
    begin
        state_next    = state_reg;
        ret_next      = ret_reg;
        cmd_next      = cmd_reg;
        run_pid_next  = run_pid_reg;
        run_vld_next  = run_vld_reg;
        err_next      = err_reg;
        prio_out_next = prio_out_reg;
        qhead_next    = qhead_reg;
        qtail_next    = qtail_reg;
        qhv_next      = qhv_reg;
        qk_next       = qk_reg;
        ql_next       = ql_reg;
        qn_next       = qn_reg;
        t_next        = t_reg;
        old_next      = old_reg;
        had_next      = had_reg;
        p_next        = p_reg;
        prev_next     = prev_reg;
        cnt_next      = cnt_reg;
        snap_next     = snap_reg;
        prevsnap_next = prevsnap_reg;
        mem_re        = 1'b0;
        mem_raddr     = '0;
        mem_we        = 1'b0;
        mem_waddr     = '0;
        mem_wdata     = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next   = cmd;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                err_next      = 1'b0;
                prio_out_next = '0;
                state_next    = S_FIN;
                unique case (cmd_reg.operation) inside
                    OP_ADMIT:
                    begin
                        if (!pid_ok || !lvl_ok || (run_vld_reg && run_pid_reg == pid_c))
                        begin
                            err_next = 1'b1;
                        end
                        else
                        begin
                            mem_we     = 1'b1;
                            mem_waddr  = pid_c;
                            mem_wdata  = ent(prio_c, ST_NEW, '0, 1'b0);
                            qk_next    = KIND_R;
                            ql_next    = prio_c;
                            qn_next    = pid_c;
                            ret_next   = S_FIN;
                            state_next = S_PUSH;
                        end
                    end
                    OP_RELEASE:
                    begin
                        state_next = S_REL;
                    end
                    OP_SETPRIO:
                    begin
                        if (!sp_ok)
                        begin
                            err_next = 1'b1;
                        end
                        else
                        begin
                            mem_re     = 1'b1;
                            mem_raddr  = pid_c;
                            state_next = S_SP_RD;
                        end
                    end
                    OP_BLOCK:
                    begin
                        if (!run_vld_reg)
                        begin
                            err_next = 1'b1;
                        end
                        else
                        begin
                            mem_re     = 1'b1;
                            mem_raddr  = run_pid_reg;
                            state_next = S_BLK_RD;
                        end
                    end
                    OP_RDYBLK:
                    begin
                        if (!bscan[LW])
                        begin
                            err_next = 1'b1;
                        end
                        else
                        begin
                            p_next     = qhead_reg[KIND_B][bscan[LW-1:0]];
                            ql_next    = bscan[LW-1:0];
                            mem_re     = 1'b1;
                            mem_raddr  = qhead_reg[KIND_B][bscan[LW-1:0]];
                            state_next = S_B4_RD;
                        end
                    end
                    OP_RDYPID, OP_GETPRIO:
                    begin
                        if (!pid_ok)
                        begin
                            err_next = 1'b1;
                        end
                        else
                        begin
                            mem_re     = 1'b1;
                            mem_raddr  = pid_c;
                            state_next = (cmd_reg.operation == OP_RDYPID) ? S_R5_RD : S_G6_RD;
                        end
                    end
                    default:
                    begin
                        err_next = 1'b1;
                    end
                endcase
            end
            // Append qn to queue (qk, ql); its own entry was written just before.
            S_PUSH:
            begin
                if (!qhv_reg[qk_reg][ql_reg])
                begin
                    qhead_next[qk_reg][ql_reg] = qn_reg;
                    qtail_next[qk_reg][ql_reg] = qn_reg;
                    qhv_next[qk_reg][ql_reg]   = 1'b1;
                    state_next                 = ret_reg;
                end
                else
                begin
                    t_next                     = qtail_reg[qk_reg][ql_reg];
                    qtail_next[qk_reg][ql_reg] = qn_reg;
                    if (int'(qtail_reg[qk_reg][ql_reg]) < NUM_PROCESSES)
                    begin
                        mem_re     = 1'b1;
                        mem_raddr  = qtail_reg[qk_reg][ql_reg];
                        state_next = S_PUSH_RD;
                    end
                    else
                    begin
                        state_next = ret_reg;
                    end
                end
            end
            S_PUSH_RD:
            begin
                mem_we     = 1'b1;
                mem_waddr  = t_reg;
                mem_wdata  = ent(rd_lvl, rd_st, qn_reg, 1'b1);
                state_next = ret_reg;
            end
            S_REL:
            begin
                had_next = run_vld_reg;
                old_next = run_pid_reg;
                if (run_vld_reg)
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = run_pid_reg;
                    state_next = S_REL_A;
                end
                else
                begin
                    state_next = S_REL_PICK;
                end
            end
            S_REL_A:
            begin
                if (rd_st == ST_RUN)
                begin
                    mem_we     = 1'b1;
                    mem_waddr  = old_reg;
                    mem_wdata  = ent(rd_lvl, ST_READY, '0, 1'b0);
                    qk_next    = KIND_R;
                    ql_next    = rd_lvl;
                    qn_next    = old_reg;
                    ret_next   = S_REL_PICK;
                    state_next = S_PUSH;
                end
                else
                begin
                    state_next = S_REL_PICK;
                end
            end
            S_REL_PICK:
            begin
                if (rel_pre && int'(ptp) < NUM_PROCESSES)
                begin
                    p_next     = PW'(ptp);
                    mem_re     = 1'b1;
                    mem_raddr  = PW'(ptp);
                    state_next = S_REL_CHK;
                end
                else if (!rscan[LW])
                begin
                    if (is_rel)
                    begin
                        err_next = 1'b1;
                    end
                    state_next = S_FIN;
                end
                else
                begin
                    p_next     = qhead_reg[KIND_R][rscan[LW-1:0]];
                    ql_next    = rscan[LW-1:0];
                    mem_re     = 1'b1;
                    mem_raddr  = qhead_reg[KIND_R][rscan[LW-1:0]];
                    state_next = S_REL_POP;
                end
            end
            S_REL_POP:
            begin
                if (p_reg == qtail_reg[KIND_R][ql_reg] || !rd_lnk)
                begin
                    qhv_next[KIND_R][ql_reg] = 1'b0;
                end
                else
                begin
                    qhead_next[KIND_R][ql_reg] = rd_nxt;
                end
                mem_we    = 1'b1;
                mem_waddr = p_reg;
                if (rel_ok)
                begin
                    mem_wdata    = ent(rd_lvl, ST_RUN, rd_nxt, 1'b0);
                    run_pid_next = p_reg;
                    run_vld_next = 1'b1;
                    state_next   = S_FIN;
                end
                else
                begin
                    mem_wdata  = ent(rd_lvl, rd_st, rd_nxt, 1'b0);
                    err_next   = is_rel ? 1'b1 : err_reg;
                    state_next = S_REL_FIX;
                end
            end
            S_REL_CHK:
            begin
                if (rel_ok)
                begin
                    mem_we       = 1'b1;
                    mem_waddr    = p_reg;
                    mem_wdata    = ent(rd_lvl, ST_RUN, rd_nxt, rd_lnk);
                    run_pid_next = p_reg;
                    run_vld_next = 1'b1;
                    state_next   = S_FIN;
                end
                else
                begin
                    err_next   = is_rel ? 1'b1 : err_reg;
                    state_next = S_REL_FIX;
                end
            end
            S_REL_FIX:
            begin
                mem_re     = 1'b1;
                mem_raddr  = old_reg;
                state_next = S_REL_FIX2;
            end
            S_REL_FIX2:
            begin
                mem_we     = 1'b1;
                mem_waddr  = old_reg;
                mem_wdata  = ent(rd_lvl, ST_RUN, rd_nxt, rd_lnk);
                state_next = S_FIN;
            end
            S_SP_RD:
            begin
                snap_next = mem_rdata;
                if (rd_lvl == prio_c)
                begin
                    state_next = S_FIN;
                end
                else if (sp_move)
                begin
                    ql_next = rd_lvl;
                    if (!qhv_reg[KIND_R][rd_lvl])
                    begin
                        err_next   = 1'b1;
                        state_next = S_FIN;
                    end
                    else if (qhead_reg[KIND_R][rd_lvl] == pid_c)
                    begin
                        if (pid_c == qtail_reg[KIND_R][rd_lvl] || !rd_lnk)
                        begin
                            qhv_next[KIND_R][rd_lvl] = 1'b0;
                        end
                        else
                        begin
                            qhead_next[KIND_R][rd_lvl] = rd_nxt;
                        end
                        state_next = S_SP_SET;
                    end
                    else
                    begin
                        prev_next  = qhead_reg[KIND_R][rd_lvl];
                        cnt_next   = '0;
                        mem_re     = 1'b1;
                        mem_raddr  = qhead_reg[KIND_R][rd_lvl];
                        state_next = S_SP_W1;
                    end
                end
                else
                begin
                    mem_we     = 1'b1;
                    mem_waddr  = pid_c;
                    mem_wdata  = ent(prio_c, rd_st, rd_nxt, rd_lnk);
                    state_next = S_REL;
                end
            end
            // One link of the walk per cycle; the entry of prev is on the read port.
            S_SP_W1:
            begin
                if (!rd_lnk)
                begin
                    err_next   = 1'b1;
                    state_next = S_FIN;
                end
                else if (rd_nxt == pid_c)
                begin
                    prevsnap_next = mem_rdata;
                    mem_re        = 1'b1;
                    mem_raddr     = pid_c;
                    state_next    = S_SP_W2;
                end
                else if (cnt_reg == CNT_LAST)
                begin
                    err_next   = 1'b1;
                    state_next = S_FIN;
                end
                else
                begin
                    prev_next = rd_nxt;
                    cnt_next  = cnt_reg + 1'b1;
                    mem_re    = 1'b1;
                    mem_raddr = rd_nxt;
                end
            end
            S_SP_W2:
            begin
                if (!rd_lnk)
                begin
                    qtail_next[KIND_R][ql_reg] = prev_reg;
                end
                mem_we     = 1'b1;
                mem_waddr  = prev_reg;
                mem_wdata  = ent(prevsnap_reg[EW-1:EW-LW], prevsnap_reg[PW+2:PW+1],
                                 rd_nxt, rd_lnk);
                state_next = S_SP_SET;
            end
            S_SP_SET:
            begin
                mem_we     = 1'b1;
                mem_waddr  = pid_c;
                mem_wdata  = ent(prio_c, snap_reg[PW+2:PW+1], '0, 1'b0);
                qk_next    = KIND_R;
                ql_next    = prio_c;
                qn_next    = pid_c;
                ret_next   = S_REL;
                state_next = S_PUSH;
            end
            S_BLK_RD:
            begin
                if (rd_st == ST_BLOCKED)
                begin
                    err_next   = 1'b1;
                    state_next = S_FIN;
                end
                else
                begin
                    mem_we     = 1'b1;
                    mem_waddr  = run_pid_reg;
                    mem_wdata  = ent(rd_lvl, ST_BLOCKED, '0, 1'b0);
                    qk_next    = KIND_B;
                    ql_next    = rd_lvl;
                    qn_next    = run_pid_reg;
                    ret_next   = S_FIN;
                    state_next = S_PUSH;
                end
            end
            S_B4_RD:
            begin
                if (p_reg == qtail_reg[KIND_B][ql_reg] || !rd_lnk)
                begin
                    qhv_next[KIND_B][ql_reg] = 1'b0;
                end
                else
                begin
                    qhead_next[KIND_B][ql_reg] = rd_nxt;
                end
                prio_out_next = rd_lvl;
                mem_we        = 1'b1;
                mem_waddr     = p_reg;
                mem_wdata     = ent(rd_lvl, ST_READY, '0, 1'b0);
                qk_next       = KIND_R;
                ql_next       = rd_lvl;
                qn_next       = p_reg;
                ret_next      = S_FIN;
                state_next    = S_PUSH;
            end
            S_R5_RD:
            begin
                mem_we     = 1'b1;
                mem_waddr  = pid_c;
                mem_wdata  = ent(rd_lvl, ST_READY, '0, 1'b0);
                qk_next    = KIND_R;
                ql_next    = rd_lvl;
                qn_next    = pid_c;
                ret_next   = S_FIN;
                state_next = S_PUSH;
            end
            S_G6_RD:
            begin
                prio_out_next = rd_lvl;
                state_next    = S_FIN;
            end
            S_FIN:
            begin
                if (ack)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            run_pid_reg <= '0;
            run_vld_reg <= 1'b0;
            qhv_reg     <= '{default: '0};
        end
        else
        begin
            state_reg   <= state_next;
            run_pid_reg <= run_pid_next;
            run_vld_reg <= run_vld_next;
            qhv_reg     <= qhv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ret_reg      <= ret_next;
        cmd_reg      <= cmd_next;
        err_reg      <= err_next;
        prio_out_reg <= prio_out_next;
        qhead_reg    <= qhead_next;
        qtail_reg    <= qtail_next;
        qk_reg       <= qk_next;
        ql_reg       <= ql_next;
        qn_reg       <= qn_next;
        t_reg        <= t_next;
        old_reg      <= old_next;
        had_reg      <= had_next;
        p_reg        <= p_next;
        prev_reg     <= prev_next;
        cnt_reg      <= cnt_next;
        snap_reg     <= snap_next;
        prevsnap_reg <= prevsnap_next;
    end

    assign idle                     = state_reg == S_IDLE;
    assign done                     = state_reg == S_FIN;
    assign result.status            = err_reg;
    assign result.running_pid_out   = PID_FW'(run_pid_reg);
    assign result.running_valid_out = run_vld_reg;
    assign result.priority_out      = PRIO_FW'(prio_out_reg);

endmodule

// ===== hw/rtl/multilevel_ready_queue_scheduler.sv =====
// ============================================================================
// multilevel_ready_queue_scheduler
// Six-level ready/blocked queue scheduler executing one kernel operation per
// request beat and returning one response beat.
// ============================================================================
//  channel | handshake            | payload
//  --------+----------------------+--------------------------
//  req     | req_valid/req_stall  | req (operation, pid, ...)
//  rsp     | rsp_valid/rsp_stall  | rsp (status, running, ...)
//  cfg     | cfg_we               | cfg_wdata (preempt target)
//
// The sequencer takes one request at a time; a request is held off while
// it works. Its duration is set by the process table, which has one read
// port and one write port with registered read: most field updates are a
// read followed by a write of the modified entry.
// Reset clears the queues and the running process at once; no sweep.
// A request is taken whenever the sequencer is idle, even while a response
// is still stalled in the output register.
module multilevel_ready_queue_scheduler #(
    parameter int NUM_PROCESSES     = mrqs_pkg::NUM_PROCESSES_DEF,
    parameter int NUM_LEVELS        = mrqs_pkg::NUM_LEVELS_DEF,
    parameter int USER_SETTABLE_MAX = mrqs_pkg::USER_SETTABLE_MAX_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        req_valid,
    output logic                        req_stall,
    input  mrqs_pkg::req_beat_t         req,
    output logic                        rsp_valid,
    input  logic                        rsp_stall,
    output mrqs_pkg::rsp_beat_t         rsp,
    input  logic                        cfg_we,
    input  logic [mrqs_pkg::PID_FW-1:0] cfg_wdata
);
    import mrqs_pkg::*;

    localparam int PW = $clog2(NUM_PROCESSES);
    localparam int LW = $clog2(NUM_LEVELS);
    localparam int EW = LW + 2 + PW + 1;

    logic [PID_FW-1:0] ptp_reg;
    rsp_beat_t         rsp_reg;
    logic              rsp_valid_reg;
    logic              seq_idle, seq_done, ack;
    rsp_beat_t         seq_result;
    logic              mem_re, mem_we;
    logic [PW-1:0]     mem_raddr, mem_waddr;
    logic [EW-1:0]     mem_wdata, mem_rdata;

    assign ack       = !rsp_valid_reg || !rsp_stall;
    assign req_stall = !seq_idle;

    mrqs_seq #(
        .NUM_PROCESSES    (NUM_PROCESSES),
        .NUM_LEVELS       (NUM_LEVELS),
        .USER_SETTABLE_MAX(USER_SETTABLE_MAX)
    ) u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (req_valid && seq_idle),
        .cmd      (req),
        .ptp      (ptp_reg),
        .ack      (ack),
        .idle     (seq_idle),
        .done     (seq_done),
        .result   (seq_result),
        .mem_re   (mem_re),
        .mem_raddr(mem_raddr),
        .mem_we   (mem_we),
        .mem_waddr(mem_waddr),
        .mem_wdata(mem_wdata),
        .mem_rdata(mem_rdata)
    );

    mrqs_entry_ram #(
        .DEPTH(NUM_PROCESSES),
        .WIDTH(EW)
    ) u_ram (
        .clk  (clk),
        .rst_n(rst_n),
        .re   (mem_re),
        .raddr(mem_raddr),
        .we   (mem_we),
        .waddr(mem_waddr),
        .wdata(mem_wdata),
        .rdata(mem_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptp_reg       <= PTP_RESET;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                ptp_reg <= cfg_wdata;
            end
            if (seq_done && ack)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (seq_done && ack)
        begin
            rsp_reg <= seq_result;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// ===== hw/rtl/mrqs_checker.sv =====
// ============================================================================
// mrqs_checker
// Port-level checks of the scheduler, bound to the top level.
// ============================================================================
module mrqs_checker #(
    parameter int NUM_LEVELS = mrqs_pkg::NUM_LEVELS_DEF
) (
    input logic                clk,
    input logic                rst_n,
    input logic                req_valid,
    input logic                req_stall,
    input logic                rsp_valid,
    input logic                rsp_stall,
    input mrqs_pkg::rsp_beat_t rsp
);
    import mrqs_pkg::*;

    // A stalled response beat holds.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("stalled response beat changed");

    // Operations are taken one at a time.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("request taken while busy");

    // Once a process runs, some process keeps running.
    a_run_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.running_valid_out |=> !rsp_valid || rsp.running_valid_out)
        else $error("running process lost");

    a_prio_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> int'(rsp.priority_out) < NUM_LEVELS)
        else $error("priority out of range");

endmodule

bind multilevel_ready_queue_scheduler mrqs_checker #(
    .NUM_LEVELS(NUM_LEVELS)
) u_mrqs_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp)
);
